[rtl/qwt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package qwt_pkg;

    // Sizes of the waypoint store and of the result values.
    localparam int MAX_WAYPOINTS = 16;
    localparam int WP_AW         = $clog2(MAX_WAYPOINTS);
    localparam int VALUE_WIDTH   = 32;
    localparam int HEAD_W        = 20;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Fixed-point constants: normalized time is Q1.24, angles are Q16.16.
    localparam logic [24:0] ONE_Q24    = 25'd16777216;
    localparam int          PI_Q16     = 205887;
    localparam int          TWO_PI_Q16 = 411774;

    // Operand and result widths of the shared multiplier.
    localparam int MUL_AW = 48;
    localparam int MUL_BW = 32;
    localparam int RES_W  = 60;

    // Command codes on the input channel.
    localparam logic [1:0] CMD_LOAD    = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_RESTART = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_TICK,
        OP_RESTART
    } qwt_op_t;

    typedef enum logic [1:0] {
        SH_0,
        SH_16,
        SH_24
    } qwt_shift_t;

    typedef struct packed {
        logic [1:0]         command;
        logic [3:0]         waypoint_index;
        logic signed [31:0] waypoint_x;
        logic signed [31:0] waypoint_y;
        logic signed [31:0] waypoint_z;
        logic signed [19:0] waypoint_heading;
    } qwt_in_t;

    typedef struct packed {
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
        logic signed [31:0] position_z;
        logic signed [31:0] velocity_x;
        logic signed [31:0] velocity_y;
        logic signed [31:0] velocity_z;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic signed [31:0] heading;
        logic               finished;
    } qwt_out_t;

    // One stored waypoint.
    typedef struct packed {
        logic signed [31:0]       x;
        logic signed [31:0]       y;
        logic signed [31:0]       z;
        logic signed [HEAD_W-1:0] h;
    } qwt_wp_t;

    // A classified item in the queue.
    typedef struct packed {
        qwt_op_t          op;
        logic [WP_AW-1:0] slot;
        qwt_wp_t          wp;
    } qwt_item_t;

    typedef struct packed {
        logic [15:0] ticks_per_segment;
        logic [24:0] tick_fraction;
        logic [24:0] inverse_segment_time;
        logic [4:0]  waypoint_count;
    } qwt_cfg_t;

    typedef struct packed {
        logic              start;
        logic [MUL_AW-1:0] a_mag;
        logic [MUL_BW-1:0] b_mag;
        logic              neg;
        qwt_shift_t        shift;
    } qwt_mul_req_t;

    typedef struct packed {
        logic                    done;
        logic signed [RES_W-1:0] result;
    } qwt_mul_rsp_t;

endpackage

`default_nettype wire

[rtl/qwt_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module qwt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[rtl/qwt_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module qwt_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  qwt_pkg::qwt_in_t   cmd_data,
    output logic               q_valid,
    output qwt_pkg::qwt_item_t q_item,
    input  logic               q_pop
);

    import qwt_pkg::*;

    qwt_item_t            q_mem_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]    count_reg, count_next;
    logic                 accept;
    logic                 push;
    qwt_item_t            item;

    // Classify the incoming command; the unused code is dropped.
    always_comb
    begin
        item.slot = cmd_data.waypoint_index;
        item.wp.x = cmd_data.waypoint_x;
        item.wp.y = cmd_data.waypoint_y;
        item.wp.z = cmd_data.waypoint_z;
        item.wp.h = cmd_data.waypoint_heading;
        case (cmd_data.command)
            CMD_LOAD:    item.op = OP_LOAD;
            CMD_TICK:    item.op = OP_TICK;
            CMD_RESTART: item.op = OP_RESTART;
            default:     item.op = OP_LOAD;
        endcase
    end

    assign cmd_stall = (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign accept    = cmd_valid && !cmd_stall;
    assign push      = accept && (cmd_data.command == CMD_LOAD ||
                                  cmd_data.command == CMD_TICK ||
                                  cmd_data.command == CMD_RESTART);
    assign q_valid   = (count_reg != '0);
    assign q_item    = q_mem_reg[rd_ptr_reg];

    // Queue pointers and fill count.
    always_comb
    begin
        wr_ptr_next = push ? QUEUE_AW'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = q_pop ? QUEUE_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !q_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

`default_nettype wire

[rtl/qwt_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

module qwt_mul (
    input  logic                  clk,
    input  logic                  rst_n,
    input  qwt_pkg::qwt_mul_req_t req,
    output qwt_pkg::qwt_mul_rsp_t rsp
);

    import qwt_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [23:0]             a_hi_reg;
    logic [MUL_BW-1:0]       b_reg;
    logic                    neg_reg;
    qwt_shift_t              sh_reg;
    logic [MUL_AW+MUL_BW-1:0] acc_reg, acc_next;
    logic [23:0]             mul_a;
    logic [MUL_BW-1:0]       mul_b;
    logic [55:0]             pp;
    logic [MUL_AW+MUL_BW-1:0] sh_mag;
    logic [RES_W-1:0]        m60;

    // One 24 x 32 multiplier takes the low half of A, then the high half.
    assign mul_a = busy_reg ? a_hi_reg : req.a_mag[23:0];
    assign mul_b = busy_reg ? b_reg : req.b_mag;
    assign pp    = mul_a * mul_b;

    always_comb
    begin
        busy_next = 1'b0;
        done_next = 1'b0;
        acc_next  = acc_reg;
        if (busy_reg)
        begin
            acc_next  = acc_reg + {pp, 24'b0};
            done_next = 1'b1;
        end
        else if (req.start)
        begin
            acc_next  = (MUL_AW+MUL_BW)'(pp);
            busy_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (req.start && !busy_reg)
        begin
            a_hi_reg <= req.a_mag[MUL_AW-1:24];
            b_reg    <= req.b_mag;
            neg_reg  <= req.neg;
            sh_reg   <= req.shift;
        end
    end

    // Shift the magnitude down, then apply the sign: truncation toward zero.
    always_comb
    begin
        case (sh_reg)
            SH_0:    sh_mag = acc_reg;
            SH_16:   sh_mag = acc_reg >> 16;
            SH_24:   sh_mag = acc_reg >> 24;
            default: sh_mag = acc_reg;
        endcase
        m60 = RES_W'(sh_mag);
    end

    assign rsp.done   = done_reg;
    assign rsp.result = neg_reg ? -$signed(m60) : $signed(m60);

endmodule

`default_nettype wire

[rtl/qwt_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module qwt_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  qwt_pkg::qwt_cfg_t           cfg,
    input  logic                        q_valid,
    input  qwt_pkg::qwt_item_t          q_item,
    output logic                        q_pop,
    output qwt_pkg::qwt_mul_req_t       mreq,
    input  qwt_pkg::qwt_mul_rsp_t       mrsp,
    output logic                        ram_we,
    output logic [qwt_pkg::WP_AW-1:0]   ram_waddr,
    output qwt_pkg::qwt_wp_t            ram_wdata,
    output logic                        ram_re,
    output logic [qwt_pkg::WP_AW-1:0]   ram_raddr,
    input  qwt_pkg::qwt_wp_t            ram_rdata,
    output logic                        sp_valid,
    input  logic                        sp_stall,
    output qwt_pkg::qwt_out_t           sp_data
);

    import qwt_pkg::*;

    localparam int WRAP_STEPS = 7;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_START,
        S_RD_END,
        S_ISSUE,
        S_WAIT,
        S_EMIT
    } state_t;

    typedef enum logic [3:0] {
        MS_U,
        MS_A,
        MS_U3,
        MS_S,
        MS_Q,
        MS_QQ,
        MS_DQ,
        MS_P,
        MS_V1,
        MS_V2,
        MS_A1,
        MS_A2,
        MS_A3,
        MS_HP
    } mstep_t;

    function automatic logic signed [VALUE_WIDTH-1:0] sat_val(
        input logic signed [RES_W-1:0] v
    );
        logic signed [RES_W-1:0] hi;
        logic signed [RES_W-1:0] lo;
        hi = (RES_W'(1) <<< (VALUE_WIDTH - 1)) - RES_W'(1);
        lo = -(RES_W'(1) <<< (VALUE_WIDTH - 1));
        if (v > hi)
        begin
            return hi[VALUE_WIDTH-1:0];
        end
        else if (v < lo)
        begin
            return lo[VALUE_WIDTH-1:0];
        end
        return v[VALUE_WIDTH-1:0];
    endfunction

    // Control state.
    state_t             state_reg, state_next;
    mstep_t             step_reg, step_next;
    logic [1:0]         axis_reg, axis_next;
    logic               hold_reg, hold_next;
    logic               fin_reg, fin_next;
    logic [WP_AW-1:0]   seg_reg, seg_next;
    logic [15:0]        phase_reg, phase_next;
    logic               sp_valid_reg, sp_valid_next;

    // Working values.
    qwt_wp_t                  start_reg, start_next;
    qwt_wp_t                  end_reg, end_next;
    logic [24:0]              u_reg, u_next;
    logic [24:0]              a_reg, a_next;
    logic [24:0]              u3_reg, u3_next;
    logic [24:0]              s_reg, s_next;
    logic [22:0]              q_reg, q_next;
    logic [25:0]              ds_reg, ds_next;
    logic signed [28:0]       dds_reg, dds_next;
    logic signed [45:0]       tmp_reg, tmp_next;
    qwt_out_t                 res_reg, res_next;
    qwt_out_t                 out_reg, out_next;

    // Derived values.
    logic [4:0]               count;
    logic [WP_AW-1:0]         last;
    logic [WP_AW-1:0]         cnt_m1;
    logic [15:0]              n_ticks;
    logic [24:0]              w;
    logic signed [30:0]       poly;
    logic signed [26:0]       ramp;
    logic signed [32:0]       e_x, e_y, e_z, e_sel;
    logic signed [31:0]       start_sel;
    logic signed [20:0]       dh;
    logic signed [22:0]       wsum;
    logic [21:0]              wv;
    logic [21:0]              wr;
    logic signed [19:0]       eh;
    logic signed [48:0]       op_a;
    logic signed [32:0]       op_b;
    logic signed [48:0]       abs_a;
    logic signed [32:0]       abs_b;
    logic signed [RES_W-1:0]  r;

    // Configuration values in their usable ranges.
    always_comb
    begin
        if (cfg.waypoint_count < 5'd2)
        begin
            count = 5'd2;
        end
        else if (cfg.waypoint_count > 5'(MAX_WAYPOINTS))
        begin
            count = 5'(MAX_WAYPOINTS);
        end
        else
        begin
            count = cfg.waypoint_count;
        end
        last    = WP_AW'(count - 5'd2);
        cnt_m1  = WP_AW'(count - 5'd1);
        n_ticks = (cfg.ticks_per_segment == 16'd0) ? 16'd1 : cfg.ticks_per_segment;
    end

    // Blend polynomial terms.
    assign w    = ONE_Q24 - u_reg;
    assign poly = 31'sd167772160 - $signed(31'(u_reg)) * 31'sd15
                  + $signed(31'(a_reg)) * 31'sd6;
    assign ramp = $signed(27'(ONE_Q24)) - $signed(27'({u_reg, 1'b0}));

    // Axis differences and the selected axis.
    assign e_x = 33'(start_reg.x) - 33'(start_reg.x) + 33'(end_reg.x) - 33'(start_reg.x);
    assign e_y = 33'(end_reg.y) - 33'(start_reg.y);
    assign e_z = 33'(end_reg.z) - 33'(start_reg.z);

    always_comb
    begin
        case (axis_reg)
            2'd0:    begin e_sel = e_x; start_sel = start_reg.x; end
            2'd1:    begin e_sel = e_y; start_sel = start_reg.y; end
            default: begin e_sel = e_z; start_sel = start_reg.z; end
        endcase
    end

    // Heading difference wrapped into [-pi, pi).
    always_comb
    begin
        dh   = 21'(end_reg.h) - 21'(start_reg.h);
        wsum = 23'(dh) + 23'(PI_Q16 + 3 * TWO_PI_Q16);
        wv   = wsum[21:0];
        wr   = wv;
        for (int k = 0; k < WRAP_STEPS; k++)
        begin
            if (wv >= 22'(k * TWO_PI_Q16))
            begin
                wr = wv - 22'(k * TWO_PI_Q16);
            end
        end
        eh = 20'($signed(23'(wr)) - 23'(PI_Q16));
    end

    // Operands of the current multiply step.
    always_comb
    begin
        op_a = '0;
        op_b = '0;
        mreq.shift = SH_24;
        case (step_reg)
            MS_U:
            begin
                op_a = 49'(phase_reg);
                op_b = 33'(cfg.tick_fraction);
                mreq.shift = SH_0;
            end
            MS_A:  begin op_a = 49'(u_reg);  op_b = 33'(u_reg); end
            MS_U3: begin op_a = 49'(a_reg);  op_b = 33'(u_reg); end
            MS_S:  begin op_a = 49'(u3_reg); op_b = 33'(poly);  end
            MS_Q:  begin op_a = 49'(u_reg);  op_b = 33'(w);     end
            MS_QQ: begin op_a = 49'(q_reg);  op_b = 33'(q_reg); end
            MS_DQ: begin op_a = 49'(q_reg);  op_b = 33'(ramp);  end
            MS_P:  begin op_a = 49'(e_sel);  op_b = 33'(s_reg); end
            MS_V1: begin op_a = 49'(e_sel);  op_b = 33'(ds_reg); end
            MS_V2:
            begin
                op_a = 49'(tmp_reg);
                op_b = 33'(cfg.inverse_segment_time);
                mreq.shift = SH_16;
            end
            MS_A1: begin op_a = 49'(e_sel);  op_b = 33'(dds_reg); end
            MS_A2, MS_A3:
            begin
                op_a = 49'(tmp_reg);
                op_b = 33'(cfg.inverse_segment_time);
                mreq.shift = SH_16;
            end
            MS_HP: begin op_a = 49'(eh);     op_b = 33'(s_reg); end
            default: begin op_a = '0; op_b = '0; end
        endcase
        abs_a      = op_a[48] ? -op_a : op_a;
        abs_b      = op_b[32] ? -op_b : op_b;
        mreq.a_mag = abs_a[MUL_AW-1:0];
        mreq.b_mag = abs_b[MUL_BW-1:0];
        mreq.neg   = op_a[48] ^ op_b[32];
        mreq.start = (state_reg == S_ISSUE);
    end

    assign r = mrsp.result;

    // Sequencer: next state and working values.
    always_comb
    begin
        state_next    = state_reg;
        step_next     = step_reg;
        axis_next     = axis_reg;
        hold_next     = hold_reg;
        fin_next      = fin_reg;
        seg_next      = seg_reg;
        phase_next    = phase_reg;
        sp_valid_next = sp_valid_reg;
        start_next    = start_reg;
        end_next      = end_reg;
        u_next        = u_reg;
        a_next        = a_reg;
        u3_next       = u3_reg;
        s_next        = s_reg;
        q_next        = q_reg;
        ds_next       = ds_reg;
        dds_next      = dds_reg;
        tmp_next      = tmp_reg;
        res_next      = res_reg;
        out_next      = out_reg;
        q_pop         = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = q_item.slot;
        ram_wdata     = q_item.wp;
        ram_re        = 1'b0;
        ram_raddr     = seg_reg;

        // The output register empties on a transfer.
        if (sp_valid_reg && !sp_stall)
        begin
            sp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_item.op)
                        OP_LOAD:
                        begin
                            ram_we = 1'b1;
                        end
                        OP_RESTART:
                        begin
                            seg_next   = '0;
                            phase_next = '0;
                            fin_next   = 1'b0;
                        end
                        OP_TICK:
                        begin
                            ram_re = 1'b1;
                            if (fin_reg || seg_reg > last)
                            begin
                                hold_next = 1'b1;
                                fin_next  = 1'b1;
                                ram_raddr = cnt_m1;
                            end
                            else
                            begin
                                hold_next = 1'b0;
                            end
                            state_next = S_RD_START;
                        end
                        default:
                        begin
                            ram_we = 1'b0;
                        end
                    endcase
                end
            end

            S_RD_START:
            begin
                start_next = ram_rdata;
                if (hold_reg)
                begin
                    res_next.position_x = ram_rdata.x;
                    res_next.position_y = ram_rdata.y;
                    res_next.position_z = ram_rdata.z;
                    res_next.heading    = 32'(ram_rdata.h);
                    res_next.velocity_x = '0;
                    res_next.velocity_y = '0;
                    res_next.velocity_z = '0;
                    res_next.accel_x    = '0;
                    res_next.accel_y    = '0;
                    res_next.accel_z    = '0;
                    res_next.finished   = 1'b1;
                    state_next          = S_EMIT;
                end
                else
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = WP_AW'(seg_reg + 1'b1);
                    state_next = S_RD_END;
                end
            end

            S_RD_END:
            begin
                end_next          = ram_rdata;
                res_next.finished = 1'b0;
                step_next         = MS_U;
                axis_next         = 2'd0;
                state_next        = S_ISSUE;
            end

            S_ISSUE:
            begin
                state_next = S_WAIT;
            end

            S_WAIT:
            begin
                if (mrsp.done)
                begin
                    state_next = S_ISSUE;
                    step_next  = mstep_t'(step_reg + 4'd1);
                    case (step_reg)
                        MS_U:
                        begin
                            if (phase_reg >= n_ticks || r > $signed(RES_W'(ONE_Q24)))
                            begin
                                u_next = ONE_Q24;
                            end
                            else
                            begin
                                u_next = r[24:0];
                            end
                        end
                        MS_A:  a_next  = r[24:0];
                        MS_U3: u3_next = r[24:0];
                        MS_S:
                        begin
                            if (r < 0)
                            begin
                                s_next = '0;
                            end
                            else if (r > $signed(RES_W'(ONE_Q24)))
                            begin
                                s_next = ONE_Q24;
                            end
                            else
                            begin
                                s_next = r[24:0];
                            end
                        end
                        MS_Q:  q_next   = r[22:0];
                        MS_QQ: ds_next  = 26'(r[25:0] * 26'd30);
                        MS_DQ: dds_next = 29'($signed(r[28:0]) * 29'sd60);
                        MS_P:
                        begin
                            case (axis_reg)
                                2'd0:    res_next.position_x = sat_val(RES_W'(start_sel) + r);
                                2'd1:    res_next.position_y = sat_val(RES_W'(start_sel) + r);
                                default: res_next.position_z = sat_val(RES_W'(start_sel) + r);
                            endcase
                        end
                        MS_V1: tmp_next = r[45:0];
                        MS_V2:
                        begin
                            case (axis_reg)
                                2'd0:    res_next.velocity_x = sat_val(r);
                                2'd1:    res_next.velocity_y = sat_val(r);
                                default: res_next.velocity_z = sat_val(r);
                            endcase
                        end
                        MS_A1: tmp_next = r[45:0];
                        MS_A2: tmp_next = r[45:0];
                        MS_A3:
                        begin
                            case (axis_reg)
                                2'd0:    res_next.accel_x = sat_val(r);
                                2'd1:    res_next.accel_y = sat_val(r);
                                default: res_next.accel_z = sat_val(r);
                            endcase
                            if (axis_reg == 2'd2)
                            begin
                                step_next = MS_HP;
                            end
                            else
                            begin
                                axis_next = axis_reg + 2'd1;
                                step_next = MS_P;
                            end
                        end
                        MS_HP:
                        begin
                            res_next.heading = sat_val(RES_W'(start_reg.h) + r);
                            state_next       = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end

            S_EMIT:
            begin
                if (!sp_valid_reg || !sp_stall)
                begin
                    out_next      = res_reg;
                    sp_valid_next = 1'b1;
                    state_next    = S_IDLE;
                    // Advance time after a setpoint on a segment.
                    if (!hold_reg)
                    begin
                        if (phase_reg < n_ticks)
                        begin
                            phase_next = phase_reg + 16'd1;
                        end
                        else if (seg_reg < last)
                        begin
                            seg_next   = seg_reg + 1'b1;
                            phase_next = 16'd1;
                        end
                        else
                        begin
                            fin_next = 1'b1;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            step_reg     <= MS_U;
            axis_reg     <= 2'd0;
            hold_reg     <= 1'b0;
            fin_reg      <= 1'b0;
            seg_reg      <= '0;
            phase_reg    <= '0;
            sp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            axis_reg     <= axis_next;
            hold_reg     <= hold_next;
            fin_reg      <= fin_next;
            seg_reg      <= seg_next;
            phase_reg    <= phase_next;
            sp_valid_reg <= sp_valid_next;
        end
    end

    // Data path registers.
    always_ff @(posedge clk)
    begin
        start_reg <= start_next;
        end_reg   <= end_next;
        u_reg     <= u_next;
        a_reg     <= a_next;
        u3_reg    <= u3_next;
        s_reg     <= s_next;
        q_reg     <= q_next;
        ds_reg    <= ds_next;
        dds_reg   <= dds_next;
        tmp_reg   <= tmp_next;
        res_reg   <= res_next;
        out_reg   <= out_next;
    end

    assign sp_valid = sp_valid_reg;
    assign sp_data  = out_reg;

endmodule

`default_nettype wire

[rtl/quintic_waypoint_trajectory_core.sv]
// Quintic waypoint trajectory core.
// Commands enter on the cmd channel (cmd_valid, cmd_stall, cmd_data): load a
// waypoint slot, advance time by one tick, or restart trajectory time. Only a
// tick produces a setpoint transfer on the sp channel (sp_valid, sp_stall,
// sp_data); loads and restarts are absorbed, and the unused code is dropped.
// A two-entry queue decouples command intake from the execution unit.
// A load is written to the waypoint store as the execution unit pops it. A
// tick on a segment makes two waypoint store reads and 26 products on one
// shared 24 x 32 multiplier before sp_valid; a tick after the last segment
// end holds the final waypoint. The next command is taken while a setpoint
// waits in the output register. When the receiver stalls, the setpoint holds
// and the execution unit waits to deliver the following one; the queue then
// fills and cmd_stall rises. Reset clears trajectory time, the queue and the
// output register and loads the default configuration; the waypoint store is
// undefined until loaded. Configuration is to be written over the APB-style
// port while the core is idle; the core itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module quintic_waypoint_trajectory_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  qwt_pkg::qwt_in_t   cmd_data,
    output logic               sp_valid,
    input  logic               sp_stall,
    output qwt_pkg::qwt_out_t  sp_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    import qwt_pkg::*;

    localparam logic [1:0] REG_TICKS = 2'd0;
    localparam logic [1:0] REG_FRAC  = 2'd1;
    localparam logic [1:0] REG_INV   = 2'd2;
    localparam logic [1:0] REG_COUNT = 2'd3;

    qwt_cfg_t      cfg_reg;
    logic          q_valid;
    qwt_item_t     q_item;
    logic          q_pop;
    qwt_mul_req_t  mreq;
    qwt_mul_rsp_t  mrsp;
    logic          ram_we;
    logic [WP_AW-1:0] ram_waddr;
    qwt_wp_t       ram_wdata;
    logic          ram_re;
    logic [WP_AW-1:0] ram_raddr;
    qwt_wp_t       ram_rdata;
    logic          cfg_write;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_segment    <= 16'd250;
            cfg_reg.tick_fraction        <= 25'd67109;
            cfg_reg.inverse_segment_time <= 25'd13107;
            cfg_reg.waypoint_count       <= 5'd7;
        end
        else if (cfg_write)
        begin
            case (paddr[3:2])
                REG_TICKS: cfg_reg.ticks_per_segment    <= pwdata[15:0];
                REG_FRAC:  cfg_reg.tick_fraction        <= pwdata[24:0];
                REG_INV:   cfg_reg.inverse_segment_time <= pwdata[24:0];
                REG_COUNT: cfg_reg.waypoint_count       <= pwdata[4:0];
                default:   cfg_reg.waypoint_count       <= cfg_reg.waypoint_count;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_TICKS: prdata = 32'(cfg_reg.ticks_per_segment);
            REG_FRAC:  prdata = 32'(cfg_reg.tick_fraction);
            REG_INV:   prdata = 32'(cfg_reg.inverse_segment_time);
            REG_COUNT: prdata = 32'(cfg_reg.waypoint_count);
            default:   prdata = '0;
        endcase
    end

    // Command intake and queue.
    qwt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_data  (cmd_data),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    // Execution unit.
    qwt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .mreq      (mreq),
        .mrsp      (mrsp),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .sp_valid  (sp_valid),
        .sp_stall  (sp_stall),
        .sp_data   (sp_data)
    );

    // Shared multiplier.
    qwt_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mreq),
        .rsp   (mrsp)
    );

    // Waypoint store.
    qwt_ram #(
        .WIDTH ($bits(qwt_wp_t)),
        .DEPTH (MAX_WAYPOINTS)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

`ifndef SYNTHESIS
    // The execution unit only takes an item that the queue holds.
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid)
        else $error("queue popped while empty");

    // After a product is issued, the multiplier goes busy and then flags it done.
    a_mul_latency: assert property (@(posedge clk) disable iff (!rst_n)
        mreq.start |-> ##2 mrsp.done)
        else $error("multiplier result missing");

    // Products are issued one at a time.
    a_mul_single: assert property (@(posedge clk) disable iff (!rst_n)
        mreq.start |=> !mreq.start)
        else $error("multiplier issued twice in a row");

    // A held final setpoint carries no motion.
    a_hold_rest: assert property (@(posedge clk) disable iff (!rst_n)
        (sp_valid && sp_data.finished) |->
            (sp_data.velocity_x == 0 && sp_data.velocity_y == 0 &&
             sp_data.velocity_z == 0 && sp_data.accel_x == 0 &&
             sp_data.accel_y == 0 && sp_data.accel_z == 0))
        else $error("finished setpoint with motion");
`endif

endmodule

`default_nettype wire
